@@ src/ptru_pkg.sv @@
// ----------------------------------------------------------------------------
// ptru_pkg
// Shared constants and types of the row unpredictor: filter tags, status
// codes, register indexes and the operand bundle of the reconstruction unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptru_pkg;

  localparam int DEF_MAX_ROW_BYTES = 4096;
  localparam int DEF_MAX_STRIDE    = 8;

  // png filter tags
  localparam logic [2:0] FILT_NONE    = 3'd0;
  localparam logic [2:0] FILT_SUB     = 3'd1;
  localparam logic [2:0] FILT_UP      = 3'd2;
  localparam logic [2:0] FILT_AVERAGE = 3'd3;
  localparam logic [2:0] FILT_PAETH   = 3'd4;

  // result status
  localparam logic [1:0] STAT_DATA      = 2'd0;
  localparam logic [1:0] STAT_CLEAN_END = 2'd1;
  localparam logic [1:0] STAT_TRUNCATED = 2'd2;
  localparam logic [1:0] STAT_BAD_TAG   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_PNG_MODE     = 2'd0;
  localparam logic [1:0] REG_ROW_BYTES    = 2'd1;
  localparam logic [1:0] REG_PIXEL_STRIDE = 2'd2;

  localparam int CFG_DATA_W = 13;

  typedef struct packed {
    logic [2:0] filter;
    logic [7:0] data;
    logic [7:0] left;
    logic [7:0] up;
    logic [7:0] up_left;
  } ptru_recon_in_t;

endpackage

`default_nettype wire

@@ src/ptru_ram.sv @@
// ----------------------------------------------------------------------------
// ptru_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ src/ptru_recon.sv @@
// ----------------------------------------------------------------------------
// ptru_recon
// Reconstructs one byte from its filtered value and its left, upper and
// upper-left neighbors according to the row filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptru_recon
  import ptru_pkg::*;
(
  input  wire ptru_recon_in_t op,
  output logic [7:0]          val
);

  logic signed [10:0] pa;
  logic signed [10:0] pb;
  logic signed [10:0] pc;
  logic signed [10:0] pc_raw;
  logic [8:0]         avg_sum;
  logic [7:0]         paeth;
  logic [7:0]         pred;

  always_comb begin
    // distances from a + b - c to each of a, b and c
    pa = 11'(signed'({3'b0, op.up})) - 11'(signed'({3'b0, op.up_left}));
    pb = 11'(signed'({3'b0, op.left})) - 11'(signed'({3'b0, op.up_left}));
    pc_raw = pa + pb;
    if (pa < 0) pa = -pa;
    if (pb < 0) pb = -pb;
    pc = (pc_raw < 0) ? -pc_raw : pc_raw;
    if (pa <= pb && pa <= pc) begin
      paeth = op.left;
    end else if (pb <= pc) begin
      paeth = op.up;
    end else begin
      paeth = op.up_left;
    end

    avg_sum = {1'b0, op.left} + {1'b0, op.up};

    case (op.filter)
      FILT_SUB:     pred = op.left;
      FILT_UP:      pred = op.up;
      FILT_AVERAGE: pred = avg_sum[8:1];
      FILT_PAETH:   pred = paeth;
      default:      pred = 8'd0;
    endcase

    val = op.data + pred;
  end

endmodule

`default_nettype wire

@@ src/png_tiff_row_unpredictor_core.sv @@
// ----------------------------------------------------------------------------
// png_tiff_row_unpredictor_core
// Undoes PNG row filters or TIFF horizontal differencing on a byte stream.
//
// Input channel (in_valid / in_stall): one source byte or an end-of-data mark
// per transfer. In PNG mode the first byte of every row is the filter tag and
// yields no result. Output channel (out_valid / out_stall): one reconstructed
// byte with its row-end mark, or a status result (clean end, truncated row,
// invalid tag) after which the block drops all input until reset.
// Configuration (cfg_valid / cfg_ready, always ready) is to be written only
// while idle, by the user; the block itself does not enforce this.
// Throughput is one byte per clock while the output is not stalled. A byte is
// registered with the synchronous read of the previous row memory into the
// stage in front of the output register, then reconstructed into the output
// register and written back. A row length of one in TIFF mode reads the entry
// written back in the same cycle; that value is forwarded. Entries of the row
// memory above its fill mark read as zero, so no clearing pass follows reset.
// Reset empties the pipeline and returns to a row start with a zero previous
// row. A stalled output holds its result; the input stalls only once the
// stage in front of the output register is full as well.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module png_tiff_row_unpredictor_core
  import ptru_pkg::*;
#(
  parameter int MAX_ROW_BYTES = DEF_MAX_ROW_BYTES,
  parameter int MAX_STRIDE    = DEF_MAX_STRIDE
) (
  input  wire logic                  clk,
  input  wire logic                  rst,

  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,

  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [7:0]            in_byte,
  input  wire logic                  source_end,

  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [7:0]                 out_byte,
  output logic                       row_end,
  output logic [1:0]                 status
);

  localparam int PW = $clog2(MAX_ROW_BYTES);
  localparam int LW = PW + 1;
  localparam int SW = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1;

  localparam logic [1:0] PH_ROW_START = 2'd0;
  localparam logic [1:0] PH_IN_ROW    = 2'd1;
  localparam logic [1:0] PH_HALTED    = 2'd2;

  // configuration registers
  logic        png_mode;
  logic [12:0] row_bytes;
  logic [3:0]  pixel_stride;

  // control state
  logic [1:0]    phase;
  logic [PW-1:0] position;
  logic [2:0]    row_filter;
  logic [LW-1:0] fill;

  logic [7:0] left_hist [MAX_STRIDE];
  logic [7:0] ul_hist   [MAX_STRIDE];

  // stage in front of the output register
  logic          s1_valid;
  logic          s1_is_status;
  logic [1:0]    s1_status;
  logic [7:0]    s1_byte;
  logic [PW-1:0] s1_pos;
  logic          s1_end;
  logic [2:0]    s1_filter;
  logic          s1_has_left;
  logic [SW-1:0] s1_sidx;
  logic          s1_fwd;
  logic [7:0]    s1_fwd_data;
  logic          s1_up_zero;

  logic          in_accept;
  logic          advance;
  logic          load_data;
  logic          load_status;
  logic [1:0]    load_code;
  logic [PW-1:0] cur_pos;
  logic [LW-1:0] len_eff;
  logic [5:0]    stride_eff;
  logic          cur_end;

  logic          wr_en;
  logic [7:0]    rd_data;
  logic [7:0]    up_val;
  logic [7:0]    recon_val;
  ptru_recon_in_t recon_op;

  assign cfg_ready = 1'b1;

  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;
  assign in_accept = in_valid && !in_stall;
  assign wr_en     = advance && !s1_is_status;

  always_comb begin
    if (row_bytes == 13'd0) begin
      len_eff = LW'(1);
    end else if (32'(row_bytes) > 32'(MAX_ROW_BYTES)) begin
      len_eff = LW'(MAX_ROW_BYTES);
    end else begin
      len_eff = LW'(row_bytes);
    end

    if (pixel_stride == 4'd0) begin
      stride_eff = 6'd1;
    end else if (32'(pixel_stride) > 32'(MAX_STRIDE)) begin
      stride_eff = 6'(MAX_STRIDE);
    end else begin
      stride_eff = {2'b00, pixel_stride};
    end

    cur_pos = (phase == PH_ROW_START) ? '0 : position;
    cur_end = ({1'b0, cur_pos} + LW'(1)) >= len_eff;

    load_data   = 1'b0;
    load_status = 1'b0;
    load_code   = STAT_DATA;
    if (in_accept && phase != PH_HALTED) begin
      if (source_end) begin
        load_status = 1'b1;
        load_code   = (phase == PH_ROW_START) ? STAT_CLEAN_END : STAT_TRUNCATED;
      end else if (phase == PH_ROW_START && png_mode) begin
        if (in_byte > {5'd0, FILT_PAETH}) begin
          load_status = 1'b1;
          load_code   = STAT_BAD_TAG;
        end
      end else begin
        load_data = 1'b1;
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      png_mode     <= 1'b1;
      row_bytes    <= 13'd1;
      pixel_stride <= 4'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PNG_MODE:     png_mode     <= cfg_data[0];
        REG_ROW_BYTES:    row_bytes    <= cfg_data[12:0];
        REG_PIXEL_STRIDE: pixel_stride <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // row sequencing, decided at the input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_ROW_START;
      position   <= '0;
      row_filter <= FILT_NONE;
    end else if (in_accept && phase != PH_HALTED) begin
      if (load_status) begin
        phase <= PH_HALTED;
      end else if (!load_data) begin
        row_filter <= in_byte[2:0];
        position   <= '0;
        phase      <= PH_IN_ROW;
      end else if (cur_end) begin
        position <= '0;
        phase    <= PH_ROW_START;
      end else begin
        position <= cur_pos + PW'(1);
        phase    <= PH_IN_ROW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load_data || load_status) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_data || load_status) begin
      s1_is_status <= load_status;
      s1_status    <= load_code;
      s1_byte      <= in_byte;
      s1_pos       <= cur_pos;
      s1_end       <= cur_end;
      s1_filter    <= png_mode ? row_filter : FILT_SUB;
      s1_has_left  <= 32'(cur_pos) >= 32'(stride_eff);
      s1_sidx      <= SW'(stride_eff - 6'd1);
      // same entry written back this cycle: take the new value
      s1_fwd       <= wr_en && (s1_pos == cur_pos);
      s1_fwd_data  <= recon_val;
      s1_up_zero   <= {1'b0, cur_pos} >= fill;
    end
  end

  ptru_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ROW_BYTES)
  ) u_prior_row (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (s1_pos),
    .wr_data (recon_val),
    .rd_en   (load_data),
    .rd_addr (cur_pos),
    .rd_data (rd_data)
  );

  always_comb begin
    if (s1_fwd) begin
      up_val = s1_fwd_data;
    end else if (s1_up_zero) begin
      up_val = 8'd0;
    end else begin
      up_val = rd_data;
    end

    recon_op.filter  = s1_filter;
    recon_op.data    = s1_byte;
    recon_op.left    = s1_has_left ? left_hist[s1_sidx] : 8'd0;
    recon_op.up      = up_val;
    recon_op.up_left = s1_has_left ? ul_hist[s1_sidx] : 8'd0;
  end

  ptru_recon u_recon (
    .op  (recon_op),
    .val (recon_val)
  );

  // histories and fill mark of the row memory
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      for (int i = 0; i < MAX_STRIDE; i++) begin
        left_hist[i] <= 8'd0;
        ul_hist[i]   <= 8'd0;
      end
    end else if (wr_en) begin
      if ({1'b0, s1_pos} >= fill) begin
        fill <= {1'b0, s1_pos} + LW'(1);
      end
      left_hist[0] <= recon_val;
      ul_hist[0]   <= up_val;
      for (int i = 1; i < MAX_STRIDE; i++) begin
        left_hist[i] <= left_hist[i-1];
        ul_hist[i]   <= ul_hist[i-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (s1_is_status) begin
        out_byte <= 8'd0;
        row_end  <= 1'b0;
        status   <= s1_status;
      end else begin
        out_byte <= recon_val;
        row_end  <= s1_end;
        status   <= STAT_DATA;
      end
    end
  end

endmodule

`default_nettype wire
